>>> rtl/qtyp_pkg.sv
// Shared constants and the arctangent table for the quaternion to yaw/pitch core.
// No dependencies.
package qtyp_pkg;

  localparam int unsigned IntFrac = 30;
  localparam int unsigned AccW = 36;  // operand and angle width, 30 fraction bits
  localparam logic signed [AccW-1:0] PiQ30 = 36'sd3373259426;
  localparam logic signed [AccW-1:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [AccW-1:0] QuarterPiQ30 = 36'sd843314857;

  // atan(2^-i) with 30 fraction bits, i = 0..30; larger i give zero.
  function automatic logic signed [AccW-1:0] atan_step(input int unsigned i);
    logic signed [AccW-1:0] r;
    case (i)
      0: r = 36'sd843314857;
      1: r = 36'sd497837829;
      2: r = 36'sd263043837;
      3: r = 36'sd133525159;
      4: r = 36'sd67021687;
      5: r = 36'sd33543516;
      6: r = 36'sd16775851;
      7: r = 36'sd8388437;
      8: r = 36'sd4194283;
      9: r = 36'sd2097149;
      10: r = 36'sd1048576;
      11: r = 36'sd524288;
      12: r = 36'sd262144;
      13: r = 36'sd131072;
      14: r = 36'sd65536;
      15: r = 36'sd32768;
      16: r = 36'sd16384;
      17: r = 36'sd8192;
      18: r = 36'sd4096;
      19: r = 36'sd2048;
      20: r = 36'sd1024;
      21: r = 36'sd512;
      22: r = 36'sd256;
      23: r = 36'sd128;
      24: r = 36'sd64;
      25: r = 36'sd32;
      26: r = 36'sd16;
      27: r = 36'sd8;
      28: r = 36'sd4;
      29: r = 36'sd2;
      30: r = 36'sd1;
      default: r = 36'sd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/qtyp_cordic.sv
// Pipelined vectoring CORDIC atan2, one register per stage.
// Depends on qtyp_pkg.
module qtyp_cordic #(
  parameter int unsigned STAGES = 16,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [qtyp_pkg::AccW:0]  y_i,
  input  logic signed [qtyp_pkg::AccW:0]  x_i,
  input  logic [SIDE_W-1:0]               side_i,
  output logic signed [qtyp_pkg::AccW-1:0] z_o,
  output logic [SIDE_W-1:0]               side_o
);
  localparam int unsigned W = qtyp_pkg::AccW + 3;

  logic signed [W-1:0] x_q [STAGES+1];
  logic signed [W-1:0] y_q [STAGES+1];
  logic signed [qtyp_pkg::AccW-1:0] z_q [STAGES+1];
  logic [SIDE_W-1:0] s_q [STAGES+1];
  logic signed [W-1:0] x0_d, y0_d;
  logic signed [qtyp_pkg::AccW-1:0] z0_d;

  // Pre-rotation into the right half plane.
  always_comb begin
    x0_d = W'(x_i);
    y0_d = W'(y_i);
    z0_d = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0_d = W'(y_i);
        y0_d = -W'(x_i);
        z0_d = qtyp_pkg::HalfPiQ30;
      end else begin
        x0_d = -W'(y_i);
        y0_d = W'(x_i);
        z0_d = -qtyp_pkg::HalfPiQ30;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= x0_d;
      y_q[0] <= y0_d;
      z_q[0] <= z0_d;
      s_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [W-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[i+1] <= s_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + qtyp_pkg::atan_step(i);
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - qtyp_pkg::atan_step(i);
        end
      end
    end
  end

  assign z_o = z_q[STAGES];
  assign side_o = s_q[STAGES];
endmodule

>>> rtl/quaternion_to_yaw_pitch_core.sv
// Top level: quaternion to azimuth/elevation converter.
// Depends on qtyp_pkg and qtyp_cordic.
//
// Usage:
//   s_axis carries one quaternion per item; tdata = {z, y, x, w}, 16 bits
//   each, Q1.15, w in the lowest bits. m_axis carries one result per item;
//   tdata = {elevation (15b), azimuth (16b)} zero filled to 32 bits, and
//   tuser carries the gimbal lock flag.
// Throughput: one item per cycle while the receiver takes results; the
//   square root (one result bit per stage) and the CORDIC pipelines make up
//   most of the pipeline depth.
// The whole pipeline advances as one unit: when the receiver holds tready
//   low with a valid output, every stage holds, and s_axis_tready falls
//   only if that stage is occupied (the output stage doubles as the skid
//   register). Reset clears all valid bits; data registers are not reset.
// Angles: s = 2(wx - zy), c = 1 - 2(x^2+y^2). |s| >= 1 locks, elevation is
//   +-pi/2 and azimuth atan2(-2xz, c); else elevation is
//   atan2(s, sqrt(1 - s^2)) and azimuth atan2(2(wy + zx), c).
//   Results round half up and clamp to +-pi and +-pi/2.
module quaternion_to_yaw_pitch_core #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 13
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // azimuth_rad[15:0], elevation_rad[30:16]
  output logic        m_axis_tuser    // gimbal_lock
);
  localparam int unsigned AccW = qtyp_pkg::AccW;
  localparam int unsigned OutShift = qtyp_pkg::IntFrac - ANGLE_FRAC_BITS;
  localparam int unsigned SqW = 31;  // root bits
  localparam int unsigned Lat = 3 + SqW + CORDIC_STAGES + 1 + 1;

  // Global enable: advance unless the output holds an untaken item.
  logic en;
  logic [Lat-1:0] vld_q;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  // Stage 1: products.
  logic signed [15:0] w, x, y, z;
  assign w = s_axis_tdata[15:0];
  assign x = s_axis_tdata[31:16];
  assign y = s_axis_tdata[47:32];
  assign z = s_axis_tdata[63:48];
  logic signed [31:0] wx_q, zy_q, xx_q, yy_q, wy_q, zx_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= w * x;
      zy_q <= z * y;
      xx_q <= x * x;
      yy_q <= y * y;
      wy_q <= w * y;
      zx_q <= z * x;
    end
  end

  // Stage 2: s, c, both azimuth numerators, lock.
  logic signed [AccW-1:0] s_q, c_q, an_q, al_q;
  logic lk_q;
  logic signed [AccW-1:0] s_d;
  assign s_d = 36'(wx_q) - 36'(zy_q) <<< 1;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q  <= s_d;
      c_q  <= (36'sd1 <<< 30) - ((36'(xx_q) + 36'(yy_q)) <<< 1);
      an_q <= (36'(wy_q) + 36'(zx_q)) <<< 1;
      al_q <= -(36'(zx_q) <<< 1);
      lk_q <= (s_d >= (36'sd1 <<< 30)) || (s_d <= -(36'sd1 <<< 30));
    end
  end

  // Stage 3: s^2 (|s| < 2^31 when unlocked; locked items ignore it).
  logic [61:0] rad_d;
  logic [30:0] sabs;
  logic [61:0] ss;
  assign sabs = s_q[35] ? 31'(-s_q) : 31'(s_q);
  assign ss = sabs * sabs;
  assign rad_d = (62'd1 << 60) - ss;
  typedef struct packed {
    logic signed [AccW-1:0] s;
    logic signed [AccW-1:0] c;
    logic signed [AccW-1:0] ay;
    logic lk;
  } side_t;
  side_t sd_q;
  logic [61:0] rad_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= rad_d;
      sd_q <= '{s: s_q, c: c_q, ay: lk_q ? al_q : an_q, lk: lk_q};
    end
  end

  // Square root: restoring, one result bit per stage.
  logic [61:0] rm_q [SqW+1];
  logic [SqW-1:0] rt_q [SqW+1];
  side_t ss_q [SqW+1];
  always_comb begin
    rm_q[0] = rad_q;
    rt_q[0] = '0;
    ss_q[0] = sd_q;
  end
  for (genvar i = 0; i < SqW; i++) begin : g_sq
    localparam int unsigned B = SqW - 1 - i;
    logic [63:0] trial;
    assign trial = ({33'd0, rt_q[i]} << (B + 1)) + (64'd1 << (2 * B));
    always_ff @(posedge clk_i) begin
      if (en) begin
        ss_q[i+1] <= ss_q[i];
        if ({2'b0, rm_q[i]} >= trial) begin
          rm_q[i+1] <= rm_q[i] - 62'(trial);
          rt_q[i+1] <= rt_q[i] | (SqW'(1) << B);
        end else begin
          rm_q[i+1] <= rm_q[i];
          rt_q[i+1] <= rt_q[i];
        end
      end
    end
  end

  side_t fin;
  logic [SqW-1:0] root;
  assign fin = ss_q[SqW];
  assign root = rt_q[SqW];

  // Zero vector gives zero: the flags ride along the CORDIC side channels.
  logic zv_a_d, zv_e_d;
  assign zv_a_d = (fin.ay == 0) && (fin.c == 0);
  assign zv_e_d = (fin.s == 0) && (root == 0);

  // CORDICs: azimuth carries its zero flag, elevation its zero flag and lock.
  logic signed [AccW-1:0] za, ze;
  logic zv_a, zv_e, lk_o;
  logic [1:0] el_side;
  qtyp_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_az (
    .clk_i, .en_i(en),
    .y_i(37'(fin.ay)), .x_i(37'(fin.c)),
    .side_i(zv_a_d), .z_o(za), .side_o(zv_a)
  );
  qtyp_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(2)) u_el (
    .clk_i, .en_i(en),
    .y_i(37'(fin.s)), .x_i({6'd0, root}),
    .side_i({zv_e_d, fin.lk}), .z_o(ze), .side_o(el_side)
  );
  assign zv_e = el_side[1];
  assign lk_o = el_side[0];

  // Final: round, clamp, lock override.
  function automatic logic signed [AccW-1:0] rnd(input logic signed [AccW-1:0] a);
    return (a + (36'sd1 <<< (OutShift - 1))) >>> OutShift;
  endfunction
  logic signed [AccW-1:0] pio, hpio, ar, er;
  assign pio = rnd(qtyp_pkg::PiQ30);
  assign hpio = rnd(qtyp_pkg::HalfPiQ30);
  always_comb begin
    ar = zv_a ? '0 : rnd(za);
    er = zv_e ? '0 : rnd(ze);
    if (ar > pio) ar = pio;
    if (ar < -pio) ar = -pio;
    if (er > hpio) er = hpio;
    if (er < -hpio) er = -hpio;
  end

  logic [15:0] az_q;
  logic [14:0] el_q;
  logic lko_q;
  logic signed [AccW-1:0] sgn_q [CORDIC_STAGES+1];
  // Keep the sign of s for the locked elevation.
  always_ff @(posedge clk_i) begin
    if (en) sgn_q[0] <= fin.s;
  end
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_sg
    always_ff @(posedge clk_i) begin
      if (en) sgn_q[i+1] <= sgn_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      az_q <= ar[15:0];
      el_q <= lk_o ? (sgn_q[CORDIC_STAGES] > 0 ? hpio[14:0] : 15'(-hpio)) : er[14:0];
      lko_q <= lk_o;
    end
  end

  assign m_axis_tdata = {1'b0, el_q, az_q};
  assign m_axis_tuser = lko_q;
endmodule
